// ===== rtl/core/pmq_pkg.sv =====
// pmq_pkg: shared types, constants and opcodes for the priority message queue
// no dependencies
package pmq_pkg;
  localparam int unsigned QueueDepth = 64;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned EntryW = 8 + 6 + 24 + 16;

  typedef enum logic [2:0] {
    OP_PUT = 3'd0, OP_GET = 3'd1, OP_FLUSH = 3'd2, OP_COUNT = 3'd3,
    OP_ABORT = 3'd4, OP_INIT = 3'd5, OP_DEINIT = 3'd6, OP_NOP = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_INIT = 3'd1, ST_EMPTY = 3'd2, ST_ABORTED = 3'd3, ST_FULL = 3'd4
  } status_e;

  localparam logic CfgHoldOutput = 1'b0;
  localparam logic CfgDataPacketType = 1'b1;

  typedef struct packed {
    logic [7:0]  prio;
    logic [5:0]  mtype;
    logic [23:0] size;
    logic [15:0] handle;
  } entry_t;

  // last member sits in the lowest bits, so status lands at bit 0
  typedef struct packed {
    logic        emptied;
    logic [31:0] data_total;
    logic [6:0]  count_out;
    logic [7:0]  priority_out;
    logic [5:0]  type_out;
    logic [15:0] handle_out;
    logic [2:0]  status;
  } result_t;
endpackage

// ===== rtl/core/priority_message_queue_top.sv =====
// priority_message_queue_top: sequenced priority queue around one entry ram
// depends on pmq_pkg and pmq_ram
//
// channel  dir  handshake          payload
// s_axis   in   tvalid/tready      opcode, handle, priority, type, match_all, size
// m_axis   out  tvalid/tready      status, handle, type, priority, count, total, emptied
// cfg      in   cfg_we_i           register index, data
//
// each request walks the entries one ram read per cycle. the ram holds entries in
// priority order, index 0 is the head. no clearing pass after reset: entries at or
// above the occupancy are never read. a new request is taken only when the result
// register is empty or being taken.
module priority_message_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], message_handle[18:3], priority_req[26:19], msg_type[32:27],
  // match_all[33], packet_size[57:34], zero fill to 64
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[2:0], handle_out[18:3], type_out[24:19], priority_out[32:25],
  // count_out[39:33], data_total[71:40], emptied[72], zero fill to 80
  output logic [79:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [5:0]  cfg_data_i
);
  import pmq_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_MOVE = 5'b00100,
    S_DONE = 5'b01000, S_HEAD = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic hold_q;
  logic [5:0] dtype_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      dtype_q <= 6'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgHoldOutput) hold_q <= cfg_data_i[0];
      else dtype_q <= cfg_data_i;
    end
  end

  // control state
  logic [CntW-1:0] occ_q, occ_d;
  logic [31:0] total_q, total_d;
  logic emptied_q, emptied_d, abort_q, abort_d, ready_q, ready_d;

  // request fields
  logic [2:0] op_q, op_d;
  entry_t req_q, req_d;
  logic all_q, all_d;

  // walk: rd is next index to read, wr is write index (keep / insert point)
  logic [CntW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [6:0] cnt_q, cnt_d;
  logic ins_q, ins_d; // put: new entry already placed, now shifting
  entry_t carry_q, carry_d; // put: entry displaced, to be written one slot on

  // result register
  logic out_v_q, out_v_d;
  result_t res_q, res_d;

  // ram
  logic ram_we;
  logic [IdxW-1:0] ram_wa, ram_ra;
  entry_t ram_wd, ram_rd;

  pmq_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  assign s_axis_tready = (state_q == S_IDLE) && (!out_v_q || m_axis_tready);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'd0, res_q};

  logic [32:0] sum;
  logic match;
  always_comb begin
    sum = {1'b0, total_q} + {9'd0, req_q.size};
    match = all_q || (ram_rd.mtype == req_q.mtype);
  end

  always_comb begin
    state_d = state_q; occ_d = occ_q; total_d = total_q; emptied_d = emptied_q;
    abort_d = abort_q; ready_d = ready_q; op_d = op_q; req_d = req_q; all_d = all_q;
    rd_d = rd_q; wr_d = wr_q; cnt_d = cnt_q; ins_d = ins_q; carry_d = carry_q;
    out_v_d = out_v_q && !m_axis_tready; res_d = res_q;
    ram_we = 1'b0; ram_wa = wr_q[IdxW-1:0]; ram_wd = carry_q;
    ram_ra = rd_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          op_d = s_axis_tdata[2:0];
          req_d.handle = s_axis_tdata[18:3];
          req_d.prio = s_axis_tdata[26:19];
          req_d.mtype = s_axis_tdata[32:27];
          // match_all only matters to flush; all_q also marks the get shift
          all_d = s_axis_tdata[33] && (s_axis_tdata[2:0] == OP_FLUSH);
          req_d.size = s_axis_tdata[57:34];
          rd_d = '0; wr_d = '0; cnt_d = '0; ins_d = 1'b0;
          ram_ra = '0;
          state_d = S_DONE;
          case (opcode_e'(s_axis_tdata[2:0]))
            OP_PUT: if (ready_q && occ_q < CntW'(QueueDepth)) begin
              state_d = (occ_q == '0) ? S_MOVE : S_SCAN;
              rd_d = CntW'(1);
            end
            OP_GET: if (ready_q && !abort_q && occ_q != '0 && !hold_q) state_d = S_HEAD;
            OP_FLUSH, OP_COUNT: if (ready_q && occ_q != '0) begin
              state_d = S_SCAN; rd_d = CntW'(1);
            end
            default: ;
          endcase
        end
      end
      // ram_rd holds entry rd_q-1
      S_SCAN: begin
        case (opcode_e'(op_q))
          OP_PUT: begin
            if (!ins_q && ram_rd.prio < req_q.prio) begin
              ram_we = 1'b1; ram_wd = req_q; ins_d = 1'b1;
              carry_d = ram_rd; wr_d = rd_q;
            end else if (ins_q) begin
              ram_we = 1'b1; ram_wd = carry_q; carry_d = ram_rd; wr_d = rd_q;
            end else begin
              wr_d = rd_q;
            end
            if (rd_q == occ_q) begin
              state_d = S_MOVE;
              if (!ins_q && !(ram_rd.prio < req_q.prio)) carry_d = req_q;
              else if (!ins_q) carry_d = ram_rd;
            end else rd_d = rd_q + 1'b1;
          end
          OP_COUNT: begin
            if (ram_rd.mtype == req_q.mtype) cnt_d = cnt_q + 1'b1;
            if (rd_q == occ_q) state_d = S_DONE; else rd_d = rd_q + 1'b1;
          end
          default: begin // flush
            if (!match) begin
              ram_we = 1'b1; ram_wd = ram_rd; wr_d = wr_q + 1'b1;
            end
            if (rd_q == occ_q) begin
              state_d = S_DONE;
              occ_d = match ? wr_q : wr_q + 1'b1;
            end else rd_d = rd_q + 1'b1;
          end
        endcase
      end
      S_MOVE: begin // put: final write of the last carried entry, or of the new entry into an empty queue
        ram_we = 1'b1;
        ram_wd = (occ_q == '0) ? req_q : carry_q;
        ram_wa = (occ_q == '0) ? '0 : occ_q[IdxW-1:0];
        occ_d = occ_q + 1'b1;
        if (req_q.mtype == dtype_q) total_d = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        state_d = S_DONE;
        op_d = OP_NOP; // result status ok
      end
      S_HEAD: begin // get: ram_rd is the head
        if (ram_rd.prio < req_q.prio) begin
          op_d = OP_NOP; res_d.status = ST_EMPTY;
          state_d = S_DONE; cnt_d = 7'h7F;
        end else begin
          res_d.handle_out = ram_rd.handle;
          res_d.type_out = ram_rd.mtype;
          res_d.priority_out = ram_rd.prio;
          if (ram_rd.mtype == dtype_q) begin
            total_d = ({8'd0, ram_rd.size} >= total_q) ? '0 : total_q - {8'd0, ram_rd.size};
            emptied_d = ({8'd0, ram_rd.size} >= total_q);
          end
          occ_d = occ_q - 1'b1;
          wr_d = '0; rd_d = CntW'(2); ram_ra = IdxW'(1);
          state_d = (occ_q == CntW'(1)) ? S_DONE : S_MOVE;
          op_d = OP_GET; cnt_d = '0;
          if (occ_q != CntW'(1)) state_d = S_SCAN;
          all_d = 1'b1; // mark get-shift mode
          op_d = OP_ABORT;
        end
      end
      default: begin // S_DONE
        out_v_d = 1'b1;
        res_d.count_out = '0;
        if (cnt_q != 7'h7F) begin
          res_d.status = ST_OK;
          if (op_q != OP_ABORT || !all_q) begin
            res_d.handle_out = '0; res_d.type_out = '0; res_d.priority_out = '0;
          end
        end else begin
          res_d.handle_out = '0; res_d.type_out = '0; res_d.priority_out = '0;
        end
        case (opcode_e'(op_q))
          OP_PUT: res_d.status = !ready_q ? ST_NOT_INIT : ST_FULL;
          OP_GET: res_d.status = !ready_q ? ST_NOT_INIT : abort_q ? ST_ABORTED : ST_EMPTY;
          OP_FLUSH: if (all_q || req_q.mtype == dtype_q) begin
            total_d = '0; emptied_d = 1'b1;
          end
          OP_COUNT: res_d.count_out = cnt_q;
          OP_ABORT: if (!all_q) abort_d = 1'b1;
          OP_INIT, OP_DEINIT: begin
            occ_d = '0; total_d = '0; abort_d = 1'b0; emptied_d = 1'b1;
            ready_d = (op_q == OP_INIT);
          end
          default: ;
        endcase
        res_d.data_total = total_d;
        res_d.emptied = emptied_d;
        state_d = S_IDLE;
      end
    endcase

    // get shift: reuse S_SCAN with op ABORT and all set
    if (state_q == S_SCAN && op_q == OP_ABORT) begin
      ram_we = 1'b1; ram_wd = ram_rd; ram_wa = wr_q[IdxW-1:0];
      wr_d = wr_q + 1'b1;
      cnt_d = '0; occ_d = occ_q;
      total_d = total_q; emptied_d = emptied_q;
      if (rd_q > occ_q) state_d = S_DONE;
      else begin state_d = S_SCAN; rd_d = rd_q + 1'b1; end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; occ_q <= '0; total_q <= '0; emptied_q <= 1'b1;
      abort_q <= 1'b0; ready_q <= 1'b0; out_v_q <= 1'b0;
      rd_q <= '0; wr_q <= '0; cnt_q <= '0; ins_q <= 1'b0; op_q <= OP_NOP; all_q <= 1'b0;
    end else begin
      state_q <= state_d; occ_q <= occ_d; total_q <= total_d; emptied_q <= emptied_d;
      abort_q <= abort_d; ready_q <= ready_d; out_v_q <= out_v_d;
      rd_q <= rd_d; wr_q <= wr_d; cnt_q <= cnt_d; ins_q <= ins_d; op_q <= op_d;
      all_q <= all_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; carry_q <= carry_d; res_q <= res_d;
  end
endmodule

// ===== rtl/core/pmq_ram.sv =====
// pmq_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing
module pmq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
